@@ rtl/rxs_pkg.sv @@
// ----------------------------------------------------------------------------
// rxs_pkg: shared definitions for the record exchange sorter
// Field widths, the default capacity and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rxs_pkg;

    localparam int ENTRIES_DEFAULT = 64;
    localparam int KEY_W           = 17;
    localparam int TAG_W           = 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;      // write one record into the store
        logic wr_src_in;  // 1: write the input transaction, 0: write the held record
        logic cur_load;   // load the held record from the read register
        logic emit;       // present the read record on the result ports
        logic emit_last;  // the presented record closes the run
        logic emit_ovf;   // the batch dropped records
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic gt;         // held key is greater than the key just read
    } t_stat;

endpackage

@@ rtl/rxs_datapath.sv @@
// ----------------------------------------------------------------------------
// rxs_datapath: record store, held record, key compare and result registers
// One write and one registered read per cycle on the key and tag stores.
// ----------------------------------------------------------------------------
module rxs_datapath #(
    parameter int ENTRIES = rxs_pkg::ENTRIES_DEFAULT,
    localparam int AW     = $clog2(ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rxs_pkg::t_cmd            i_cmd,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [AW-1:0]            i_rd_addr,
    input  logic [rxs_pkg::KEY_W-1:0] i_sort_key,
    input  logic [rxs_pkg::TAG_W-1:0] i_record_tag,
    output rxs_pkg::t_stat           o_stat,
    output logic                     o_out_valid,
    output logic [rxs_pkg::KEY_W-1:0] o_out_key,
    output logic [rxs_pkg::TAG_W-1:0] o_out_tag,
    output logic                     o_out_last,
    output logic                     o_overflow
);

    logic [rxs_pkg::KEY_W-1:0] mem_key [ENTRIES];
    logic [rxs_pkg::TAG_W-1:0] mem_tag [ENTRIES];

    logic [rxs_pkg::KEY_W-1:0] r_rd_key;
    logic [rxs_pkg::TAG_W-1:0] r_rd_tag;
    logic [rxs_pkg::KEY_W-1:0] r_cur_key;
    logic [rxs_pkg::TAG_W-1:0] r_cur_tag;
    logic                      r_vld;
    logic                      r_last;
    logic                      r_ovf;

    logic [rxs_pkg::KEY_W-1:0] wr_key;
    logic [rxs_pkg::TAG_W-1:0] wr_tag;

    // Pick the write data: new transaction or the held record
    always_comb begin
        wr_key = i_cmd.wr_src_in ? i_sort_key   : r_cur_key;
        wr_tag = i_cmd.wr_src_in ? i_record_tag : r_cur_tag;
    end

    // Write and read the record store
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_key[i_wr_addr] <= wr_key;
            mem_tag[i_wr_addr] <= wr_tag;
        end
        r_rd_key <= mem_key[i_rd_addr];
        r_rd_tag <= mem_tag[i_rd_addr];
    end

    // Hold the record of the current outer slot
    always_ff @(posedge i_clk) begin
        if (i_cmd.cur_load) begin
            r_cur_key <= r_rd_key;
            r_cur_tag <= r_rd_tag;
        end
    end

    // Mark results in the cycle after their read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_vld  <= i_cmd.emit;
            r_last <= i_cmd.emit && i_cmd.emit_last;
            r_ovf  <= i_cmd.emit && i_cmd.emit_ovf;
        end
    end

    assign o_stat.gt   = r_cur_key > r_rd_key;
    assign o_out_valid = r_vld;
    assign o_out_key   = r_rd_key;
    assign o_out_tag   = r_rd_tag;
    assign o_out_last  = r_last;
    assign o_overflow  = r_ovf;

endmodule

@@ rtl/rxs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rxs_ctrl: sequencer for load, exchange sort and output
// Keeps the fill count, the drop flag and the slot counters.
// ----------------------------------------------------------------------------
module rxs_ctrl #(
    parameter int ENTRIES = rxs_pkg::ENTRIES_DEFAULT,
    localparam int AW     = $clog2(ENTRIES),
    localparam int CW     = $clog2(ENTRIES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_batch_end,
    input  rxs_pkg::t_stat i_stat,
    output logic          busy,
    output rxs_pkg::t_cmd o_cmd,
    output logic [AW-1:0] o_wr_addr,
    output logic [AW-1:0] o_rd_addr
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOADX = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_WBX   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_fill,  n_fill;
    logic          r_drop,  n_drop;
    logic [AW-1:0] r_x,     n_x;
    logic [AW-1:0] r_j,     n_j;
    logic [AW-1:0] r_k,     n_k;

    logic [CW-1:0] fill_inc;
    logic          j_last;
    logic          k_last;

    assign fill_inc = (r_fill < FULL) ? r_fill + CW'(1) : r_fill;
    assign j_last   = (CW'(r_j) == r_fill - CW'(1));
    assign k_last   = (CW'(r_k) + CW'(1) == r_fill);

    // Sequence load, sort passes and output
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_drop    = r_drop;
        n_x       = r_x;
        n_j       = r_j;
        n_k       = r_k;
        o_cmd     = '0;
        o_wr_addr = '0;
        o_rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (r_fill < FULL) begin
                        o_cmd.wr_en     = 1'b1;
                        o_cmd.wr_src_in = 1'b1;
                        o_wr_addr       = r_fill[AW-1:0];
                        n_fill          = fill_inc;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_batch_end) begin
                        n_x = '0;
                        n_k = '0;
                        n_state = (fill_inc >= CW'(2)) ? S_LOADX : S_EMIT;
                    end
                end
            end
            S_LOADX: begin
                o_rd_addr = r_x;
                n_state   = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.cur_load = 1'b1;
                o_rd_addr      = r_x + AW'(1);
                n_j            = r_x + AW'(1);
                n_state        = S_SCAN;
            end
            S_SCAN: begin
                o_rd_addr = j_last ? r_j : r_j + AW'(1);
                if (i_stat.gt) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.cur_load = 1'b1;
                    o_wr_addr      = r_j;
                end
                if (j_last) begin
                    n_state = S_WBX;
                end else begin
                    n_j = r_j + AW'(1);
                end
            end
            S_WBX: begin
                o_cmd.wr_en = 1'b1;
                o_wr_addr   = r_x;
                o_rd_addr   = r_x + AW'(1);
                n_x         = r_x + AW'(1);
                if (CW'(r_x) + CW'(2) == r_fill) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_EMIT: begin
                o_rd_addr       = r_k;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = k_last;
                o_cmd.emit_ovf  = r_drop;
                if (k_last) begin
                    n_fill  = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + AW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_drop  <= 1'b0;
            r_x     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_drop  <= n_drop;
            r_x     <= n_x;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign busy = (r_state != S_IDLE);

    // Fill count never exceeds the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count above capacity");

    // Inner index always runs past the outer slot
    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_j > r_x))
        else $error("inner index not after outer slot");

    // Closing record returns to idle with an empty batch
    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> (r_state == S_IDLE && r_fill == '0 && !r_drop))
        else $error("batch not cleared after last result");

    // Swap writes only land on the inner index during a scan
    a_swap_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_cmd.wr_en) |-> (o_wr_addr == r_j && CW'(r_j) < r_fill))
        else $error("swap write outside loaded slots");

    // Results are only issued from the output state
    a_emit_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_EMIT))
        else $error("result issued outside output state");

endmodule

@@ rtl/record_exchange_sort.sv @@
// ----------------------------------------------------------------------------
// record_exchange_sort: batch loader with an ascending exchange sort
// Stores records until the batch end, sorts them in place and streams them out.
//
//   channel  | handshake               | fields
//   ---------+-------------------------+------------------------------------------
//   input    | start & !busy           | i_sort_key, i_record_tag, i_batch_end
//   result   | o_out_valid (1 cycle)   | o_out_key, o_out_tag, o_out_last, o_overflow
//
// A record without batch end is stored while the block stays idle. On batch end
// with two or more records the exchange sort runs one compare per cycle on the
// store's single read port, each outer slot fetched before its scan and written
// back after it; then the results stream out, the last in the cycle busy falls.
// Reset (synchronous, active low) empties the batch; store contents are kept.
// The result side cannot stall; busy holds off new transactions until done.
// ----------------------------------------------------------------------------
module record_exchange_sort #(
    parameter int ENTRIES = rxs_pkg::ENTRIES_DEFAULT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rxs_pkg::KEY_W-1:0] i_sort_key,
    input  logic [rxs_pkg::TAG_W-1:0] i_record_tag,
    input  logic                      i_batch_end,
    output logic                      o_out_valid,
    output logic [rxs_pkg::KEY_W-1:0] o_out_key,
    output logic [rxs_pkg::TAG_W-1:0] o_out_tag,
    output logic                      o_out_last,
    output logic                      o_overflow
);

    localparam int AW = $clog2(ENTRIES);

    rxs_pkg::t_cmd  cmd;
    rxs_pkg::t_stat stat;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;

    // Sequence the batch
    rxs_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_batch_end (i_batch_end),
        .i_stat      (stat),
        .busy        (busy),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr)
    );

    // Store, compare and present records
    rxs_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_wr_addr    (wr_addr),
        .i_rd_addr    (rd_addr),
        .i_sort_key   (i_sort_key),
        .i_record_tag (i_record_tag),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .o_out_key    (o_out_key),
        .o_out_tag    (o_out_tag),
        .o_out_last   (o_out_last),
        .o_overflow   (o_overflow)
    );

endmodule
